[design/voice_allocator_oldest_steal_defines.svh]
// Assertion macros shared by the voice allocator RTL.
`ifndef VOICE_ALLOCATOR_OLDEST_STEAL_DEFINES_SVH
`define VOICE_ALLOCATOR_OLDEST_STEAL_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define VAO_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another one at the same edge.
`define VAO_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// A condition that implies another one at the next edge.
`define VAO_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/vao_pkg.sv]
// Package with the constants and codes of the voice allocator.
`default_nettype none

package vao_pkg;

  localparam int VOICE_COUNT_DEF = 8;

  localparam int NOTE_W    = 7;
  localparam int VOICE_W   = 3;
  localparam int COMMAND_W = 2;

  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  localparam logic [COMMAND_W-1:0] CMD_TRIGGER = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_GLIDE   = 2'd2;

endpackage

`default_nettype wire

[design/voice_allocator_oldest_steal.sv]
// Voice allocator with a free voice stack and oldest-first note stealing.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------------
//   in      | input     | in_valid / in_stall       | in_op, in_note, in_velocity
//   out     | output    | out_valid / out_stall     | out_voice, out_command, out_pitch,
//           |           |                           | out_strike, out_last
//   cfg     | input     | cfg_wr_en                 | cfg_wr_data (legato mode)
//
// One item is worked on at a time; the lists live in memories with a registered read,
// so each list step costs a read. A note on with a free voice pops the free stack; a
// steal releases the oldest voice, compacts the list and pops, or in mono legato glides;
// a note off searches voice by voice, releases the match and compacts the list.
// Reset is synchronous and takes effect at once; the free stack is seeded by valid bits.
// A stalled result holds the machine only when the next result is ready to load.
`default_nettype none

`include "voice_allocator_oldest_steal_defines.svh"

module voice_allocator_oldest_steal #(
  parameter int VOICE_COUNT = vao_pkg::VOICE_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_op,
  input  wire logic [vao_pkg::NOTE_W-1:0]    in_note,
  input  wire logic [vao_pkg::NOTE_W-1:0]    in_velocity,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [vao_pkg::VOICE_W-1:0]        out_voice,
  output logic [vao_pkg::COMMAND_W-1:0]      out_command,
  output logic [vao_pkg::NOTE_W-1:0]         out_pitch,
  output logic [vao_pkg::NOTE_W-1:0]         out_strike,
  output logic                               out_last,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data
);

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CW = $clog2(VOICE_COUNT + 1);
  localparam int NW = vao_pkg::NOTE_W;
  localparam bit MONO = (VOICE_COUNT == 1);
  localparam logic [CW-1:0] FULL = CW'(VOICE_COUNT);
  localparam logic [CW:0]   ALL_VOICES = (CW+1)'(VOICE_COUNT);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_OFF_V    = 4'd1;
  localparam logic [3:0] S_OFF_CMP  = 4'd2;
  localparam logic [3:0] S_OFF_EMIT = 4'd3;
  localparam logic [3:0] S_DROP     = 4'd4;
  localparam logic [3:0] S_STEAL_V  = 4'd5;
  localparam logic [3:0] S_STEAL_P  = 4'd6;
  localparam logic [3:0] S_POP_RD   = 4'd7;
  localparam logic [3:0] S_POP      = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic          op_r, op_nxt;
  logic [NW-1:0] note_r, note_nxt;
  logic [NW-1:0] vel_r, vel_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [CW-1:0] act_cnt_r, act_cnt_nxt;
  logic [CW-1:0] free_cnt_r, free_cnt_nxt;
  logic          after_pop_r, after_pop_nxt;
  logic          legato_r;

  // Active list, oldest first.
  logic [VW-1:0] ao_mem [VOICE_COUNT];
  logic          ao_re, ao_we;
  logic [VW-1:0] ao_raddr, ao_waddr, ao_wdata, ao_rdata_r;

  // Free voice stack; an entry never written reads as its own index.
  logic [VW-1:0]          fs_mem [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] fs_valid_r;
  logic                   fs_re, fs_we, fs_init_r;
  logic [VW-1:0]          fs_raddr, fs_waddr, fs_wdata, fs_rdata_r, fs_addr_q_r, fs_voice;

  // Note held by each voice.
  logic [NW-1:0] vp_mem [VOICE_COUNT];
  logic          vp_re, vp_we;
  logic [VW-1:0] vp_raddr, vp_waddr;
  logic [NW-1:0] vp_wdata, vp_rdata_r;

  logic                          out_valid_r, out_free, out_ld;
  logic [vao_pkg::VOICE_W-1:0]   out_voice_r, out_voice_nxt;
  logic [vao_pkg::COMMAND_W-1:0] out_command_r, out_command_nxt;
  logic [NW-1:0]                 out_pitch_r, out_pitch_nxt;
  logic [NW-1:0]                 out_strike_r, out_strike_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [CW:0] idx_p1, idx_p2, act_ext, count_sum;
  logic        idle_w, off_empty_acc;

  assign idx_p1   = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2   = {1'b0, idx_r} + (CW+1)'(2);
  assign act_ext  = {1'b0, act_cnt_r};
  assign count_sum = {1'b0, act_cnt_r} + {1'b0, free_cnt_r};
  assign out_free = !out_valid_r || !out_stall;
  assign fs_voice = fs_init_r ? fs_addr_q_r : fs_rdata_r;
  assign in_stall = (state_r != S_IDLE);
  assign idle_w   = (state_r == S_IDLE);
  assign off_empty_acc = in_valid && !in_stall && (in_op == vao_pkg::OP_NOTE_OFF) &&
                         (act_cnt_r == '0);

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    note_nxt        = note_r;
    vel_nxt         = vel_r;
    idx_nxt         = idx_r;
    v_nxt           = v_r;
    act_cnt_nxt     = act_cnt_r;
    free_cnt_nxt    = free_cnt_r;
    after_pop_nxt   = after_pop_r;
    ao_re           = 1'b0;
    ao_raddr        = '0;
    ao_we           = 1'b0;
    ao_waddr        = '0;
    ao_wdata        = '0;
    fs_re           = 1'b0;
    fs_raddr        = '0;
    fs_we           = 1'b0;
    fs_waddr        = '0;
    fs_wdata        = '0;
    vp_re           = 1'b0;
    vp_raddr        = '0;
    vp_we           = 1'b0;
    vp_waddr        = '0;
    vp_wdata        = '0;
    out_ld          = 1'b0;
    out_voice_nxt   = out_voice_r;
    out_command_nxt = out_command_r;
    out_pitch_nxt   = out_pitch_r;
    out_strike_nxt  = out_strike_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          note_nxt = in_note;
          vel_nxt  = in_velocity;
          idx_nxt  = '0;
          if (in_op == vao_pkg::OP_NOTE_OFF) begin
            if (act_cnt_r != '0) begin
              ao_re     = 1'b1;
              state_nxt = S_OFF_V;
            end
          end else if (free_cnt_r == '0) begin
            if (act_cnt_r != '0) begin
              ao_re     = 1'b1;
              state_nxt = S_STEAL_V;
            end
          end else begin
            fs_re     = 1'b1;
            fs_raddr  = VW'(free_cnt_r - CW'(1));
            state_nxt = S_POP;
          end
        end
      end

      S_OFF_V: begin
        v_nxt     = ao_rdata_r;
        vp_re     = 1'b1;
        vp_raddr  = ao_rdata_r;
        state_nxt = S_OFF_CMP;
      end

      S_OFF_CMP: begin
        if (vp_rdata_r == note_r) begin
          state_nxt = S_OFF_EMIT;
        end else if (idx_p1 < act_ext) begin
          idx_nxt   = idx_p1[CW-1:0];
          ao_re     = 1'b1;
          ao_raddr  = idx_p1[VW-1:0];
          state_nxt = S_OFF_V;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_OFF_EMIT: begin
        if (out_free) begin
          out_ld          = 1'b1;
          out_voice_nxt   = vao_pkg::VOICE_W'(v_r);
          out_command_nxt = vao_pkg::CMD_RELEASE;
          out_pitch_nxt   = note_r;
          out_strike_nxt  = '0;
          out_last_nxt    = 1'b1;
          if (free_cnt_r < FULL) begin
            fs_we        = 1'b1;
            fs_waddr     = free_cnt_r[VW-1:0];
            fs_wdata     = v_r;
            free_cnt_nxt = free_cnt_r + CW'(1);
          end
          after_pop_nxt = 1'b0;
          if (idx_p1 < act_ext) begin
            ao_re     = 1'b1;
            ao_raddr  = idx_p1[VW-1:0];
            state_nxt = S_DROP;
          end else begin
            act_cnt_nxt = act_cnt_r - CW'(1);
            state_nxt   = S_IDLE;
          end
        end
      end

      // Each entry behind the dropped one moves up by one place.
      S_DROP: begin
        ao_we    = 1'b1;
        ao_waddr = idx_r[VW-1:0];
        ao_wdata = ao_rdata_r;
        idx_nxt  = idx_p1[CW-1:0];
        if (idx_p2 < act_ext) begin
          ao_re    = 1'b1;
          ao_raddr = idx_p2[VW-1:0];
        end else begin
          act_cnt_nxt = act_cnt_r - CW'(1);
          state_nxt   = after_pop_r ? S_POP_RD : S_IDLE;
        end
      end

      S_STEAL_V: begin
        v_nxt     = ao_rdata_r;
        idx_nxt   = '0;
        vp_re     = 1'b1;
        vp_raddr  = ao_rdata_r;
        state_nxt = S_STEAL_P;
      end

      S_STEAL_P: begin
        if (out_free) begin
          out_ld        = 1'b1;
          out_voice_nxt = vao_pkg::VOICE_W'(v_r);
          out_strike_nxt = '0;
          if (legato_r && MONO) begin
            vp_we           = 1'b1;
            vp_waddr        = v_r;
            vp_wdata        = note_r;
            out_command_nxt = vao_pkg::CMD_GLIDE;
            out_pitch_nxt   = note_r;
            out_last_nxt    = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            out_command_nxt = vao_pkg::CMD_RELEASE;
            out_pitch_nxt   = vp_rdata_r;
            out_last_nxt    = 1'b0;
            // The stack is empty here, so the released voice goes to its bottom.
            fs_we           = 1'b1;
            fs_waddr        = '0;
            fs_wdata        = v_r;
            free_cnt_nxt    = CW'(1);
            after_pop_nxt   = 1'b1;
            if (idx_p1 < act_ext) begin
              ao_re     = 1'b1;
              ao_raddr  = idx_p1[VW-1:0];
              state_nxt = S_DROP;
            end else begin
              act_cnt_nxt = act_cnt_r - CW'(1);
              state_nxt   = S_POP_RD;
            end
          end
        end
      end

      S_POP_RD: begin
        fs_re     = 1'b1;
        fs_raddr  = VW'(free_cnt_r - CW'(1));
        state_nxt = S_POP;
      end

      S_POP: begin
        if (out_free) begin
          free_cnt_nxt = free_cnt_r - CW'(1);
          if (act_cnt_r < FULL) begin
            ao_we       = 1'b1;
            ao_waddr    = act_cnt_r[VW-1:0];
            ao_wdata    = fs_voice;
            act_cnt_nxt = act_cnt_r + CW'(1);
          end
          vp_we           = 1'b1;
          vp_waddr        = fs_voice;
          vp_wdata        = note_r;
          out_ld          = 1'b1;
          out_voice_nxt   = vao_pkg::VOICE_W'(fs_voice);
          out_command_nxt = vao_pkg::CMD_TRIGGER;
          out_pitch_nxt   = note_r;
          out_strike_nxt  = vel_r;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_cnt_r   <= '0;
      free_cnt_r  <= FULL;
      after_pop_r <= 1'b0;
      legato_r    <= 1'b0;
      fs_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_cnt_r   <= act_cnt_nxt;
      free_cnt_r  <= free_cnt_nxt;
      after_pop_r <= after_pop_nxt;
      if (cfg_wr_en) begin
        legato_r <= cfg_wr_data;
      end
      if (fs_we) begin
        fs_valid_r[fs_waddr] <= 1'b1;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    note_r        <= note_nxt;
    vel_r         <= vel_nxt;
    idx_r         <= idx_nxt;
    v_r           <= v_nxt;
    out_voice_r   <= out_voice_nxt;
    out_command_r <= out_command_nxt;
    out_pitch_r   <= out_pitch_nxt;
    out_strike_r  <= out_strike_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (ao_we) begin
      ao_mem[ao_waddr] <= ao_wdata;
    end
    if (ao_re) begin
      ao_rdata_r <= ao_mem[ao_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    if (fs_re) begin
      fs_rdata_r  <= fs_mem[fs_raddr];
      fs_init_r   <= !fs_valid_r[fs_raddr];
      fs_addr_q_r <= fs_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (vp_we) begin
      vp_mem[vp_waddr] <= vp_wdata;
    end
    if (vp_re) begin
      vp_rdata_r <= vp_mem[vp_raddr];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_voice   = out_voice_r;
  assign out_command = out_command_r;
  assign out_pitch   = out_pitch_r;
  assign out_strike  = out_strike_r;
  assign out_last    = out_last_r;

  // Every voice is either free or active once an item is finished.
  `VAO_ASSERT_IMPLIES(a_voices_conserved, idle_w, count_sum == ALL_VOICES, "voice count lost")
  `VAO_ASSERT_HOLDS(a_counts_bounded, act_cnt_r <= FULL && free_cnt_r <= FULL, "count out of range")
  // The release of a steal is always followed by its trigger before the next item.
  `VAO_ASSERT_IMPLIES(a_idle_last, idle_w && out_valid_r, out_last_r, "item left unfinished")
  `VAO_ASSERT_IMPLIES(a_off_empty, off_empty_acc, !out_ld && state_nxt == S_IDLE, "empty note off")

endmodule

`default_nettype wire

[tb/sv/tb_voice_allocator_oldest_steal.sv]
`timescale 1ns / 1ps
// Testbench of the voice allocator: note events checked against a voice list predictor.
module tb_voice_allocator_oldest_steal;

  localparam int NV           = vao_pkg::VOICE_COUNT_DEF;
  localparam int NW           = vao_pkg::NOTE_W;
  // A note off may search the whole list without producing anything.
  localparam int DRAIN_CYCLES = 4 * NV + 40;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic          op;
    logic [NW-1:0] note;
    logic [NW-1:0] vel;
  } note_event_t;

  typedef struct packed {
    logic [vao_pkg::VOICE_W-1:0]   voice;
    logic [vao_pkg::COMMAND_W-1:0] command;
    logic [NW-1:0]                 pitch;
    logic [NW-1:0]                 strike;
    logic                          last;
  } voice_cmd_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_op = vao_pkg::OP_NOTE_ON;
  logic [NW-1:0]                 in_note = '0;
  logic [NW-1:0]                 in_velocity = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [vao_pkg::VOICE_W-1:0]   out_voice;
  logic [vao_pkg::COMMAND_W-1:0] out_command;
  logic [NW-1:0]                 out_pitch;
  logic [NW-1:0]                 out_strike;
  logic                          out_last;
  logic                          cfg_wr_en = 1'b0;
  logic                          cfg_wr_data = 1'b0;

  voice_allocator_oldest_steal #(
    .VOICE_COUNT(NV)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_note(in_note),
    .in_velocity(in_velocity),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_voice(out_voice),
    .out_command(out_command),
    .out_pitch(out_pitch),
    .out_strike(out_strike),
    .out_last(out_last),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout: allocator stopped making progress");
    $display("end of test: mismatches");
    $finish;
  end

  note_event_t pending_events[$];
  voice_cmd_t  expected_cmds[$];

  int n_pushed = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_steals = 0;
  int n_silent_offs = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;

  // Shadow of the allocator: busy voices oldest first, free stack, note per voice.
  int            busy_list[NV];
  int            busy_cnt;
  int            free_stack[NV];
  int            free_cnt;
  logic [NW-1:0] held_note[NV];
  logic          legato;

  function void clear_voices();
    for (int i = 0; i < NV; i++) begin
      busy_list[i]  = 0;
      free_stack[i] = i;
      held_note[i]  = '0;
    end
    busy_cnt = 0;
    free_cnt = NV;
    legato   = 1'b0;
  endfunction

  function void push_cmd(int v, logic [vao_pkg::COMMAND_W-1:0] cmd, logic [NW-1:0] pitch,
                         logic [NW-1:0] strike, logic last);
    voice_cmd_t c;
    c.voice   = v[vao_pkg::VOICE_W-1:0];
    c.command = cmd;
    c.pitch   = pitch;
    c.strike  = strike;
    c.last    = last;
    expected_cmds.push_back(c);
  endfunction

  function void drop_busy(int pos);
    for (int i = pos; i + 1 < busy_cnt; i++)
      busy_list[i] = busy_list[i + 1];
    if (busy_cnt > 0)
      busy_cnt--;
  endfunction

  function void allocate_voice(note_event_t e);
    int hit;
    int v;
    if (e.op == vao_pkg::OP_NOTE_OFF) begin
      hit = -1;
      for (int i = 0; i < busy_cnt; i++)
        if (hit < 0 && held_note[busy_list[i]] == e.note)
          hit = i;
      if (hit < 0) begin
        n_silent_offs++;
        return;
      end
      v = busy_list[hit];
      push_cmd(v, vao_pkg::CMD_RELEASE, e.note, '0, 1'b1);
      drop_busy(hit);
      if (free_cnt < NV)
        free_stack[free_cnt++] = v;
      return;
    end
    if (free_cnt == 0) begin
      if (busy_cnt == 0)
        return;
      v = busy_list[0];
      if (legato && NV == 1) begin
        held_note[v] = e.note;
        push_cmd(v, vao_pkg::CMD_GLIDE, e.note, '0, 1'b1);
        return;
      end
      // Steal: the oldest busy voice is released, then retriggered.
      push_cmd(v, vao_pkg::CMD_RELEASE, held_note[v], '0, 1'b0);
      drop_busy(0);
      free_stack[free_cnt++] = v;
      n_steals++;
    end
    free_cnt--;
    v = free_stack[free_cnt];
    if (busy_cnt < NV)
      busy_list[busy_cnt++] = v;
    held_note[v] = e.note;
    push_cmd(v, vao_pkg::CMD_TRIGGER, e.note, e.vel, 1'b1);
  endfunction

  // Driver: offers queued items and predicts each one as it is accepted.
  always @(posedge clk) begin
    note_event_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        allocate_voice({in_op, in_note, in_velocity});
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_events.pop_front();
          in_valid    <= 1'b1;
          in_op       <= nxt.op;
          in_note     <= nxt.note;
          in_velocity <= nxt.vel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go && hold_left == 0)
      hold_left <= HOLD_CYCLES;
    else if (hold_left > 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: every accepted command must match the oldest expected one.
  always @(posedge clk) begin
    voice_cmd_t got;
    voice_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_voice, out_command, out_pitch, out_strike, out_last};
      n_results++;
      if (expected_cmds.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected command: voice %0d cmd %0d pitch %0d strike %0d last %0d",
                   got.voice, got.command, got.pitch, got.strike, got.last);
      end else begin
        want = expected_cmds.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch: got voice %0d cmd %0d pitch %0d strike %0d last %0d,",
                     got.voice, got.command, got.pitch, got.strike, got.last);
            $display("  expected voice %0d cmd %0d pitch %0d strike %0d last %0d",
                     want.voice, want.command, want.pitch, want.strike, want.last);
          end
        end
      end
    end
  end

  function void queue_event(logic op, logic [NW-1:0] note, logic [NW-1:0] vel);
    note_event_t e;
    e.op   = op;
    e.note = note;
    e.vel  = vel;
    pending_events.push_back(e);
    n_pushed++;
  endfunction

  // Notes come mostly from a narrow pool so that note offs find held voices.
  function void queue_random(int count);
    int base;
    int off_pct;
    logic [NW-1:0] note;
    base    = int'($urandom_range(127));
    off_pct = 40;
    for (int k = 0; k < count; k++) begin
      if (k % 32 == 0)
        off_pct = int'($urandom_range(65, 15));
      if ($urandom_range(99) < 75)
        note = NW'(base + int'($urandom_range(11)));
      else
        note = NW'($urandom_range(127));
      queue_event(($urandom_range(99) < off_pct) ? vao_pkg::OP_NOTE_OFF : vao_pkg::OP_NOTE_ON,
                  note, NW'($urandom_range(127)));
    end
  endfunction

  task automatic wait_idle();
    while (!(n_accepted == n_pushed && expected_cmds.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_legato(logic mode);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    legato = mode;
  endtask

  initial begin
    clear_voices();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_legato(1'b0);
    queue_event(vao_pkg::OP_NOTE_ON, 7'd0, 7'd127);
    queue_event(vao_pkg::OP_NOTE_ON, 7'd127, 7'd0);
    queue_event(vao_pkg::OP_NOTE_OFF, 7'd127, 7'd127);
    // A note off that no voice holds produces nothing.
    queue_event(vao_pkg::OP_NOTE_OFF, 7'd55, 7'd0);
    queue_event(vao_pkg::OP_NOTE_ON, 7'd60, 7'd1);
    queue_event(vao_pkg::OP_NOTE_ON, 7'd60, 7'd2);
    for (int n = 61; n <= 65; n++)
      queue_event(vao_pkg::OP_NOTE_ON, n[NW-1:0], 7'd64);
    // All voices busy: the next two note ons steal the oldest voices.
    queue_event(vao_pkg::OP_NOTE_ON, 7'd66, 7'd100);
    queue_event(vao_pkg::OP_NOTE_ON, 7'd67, 7'd85);
    queue_event(vao_pkg::OP_NOTE_OFF, 7'd60, 7'd42);
    queue_event(vao_pkg::OP_NOTE_OFF, 7'd60, 7'd42);
    queue_event(vao_pkg::OP_NOTE_OFF, 7'd0, 7'd42);
    queue_event(vao_pkg::OP_NOTE_ON, 7'd0, 7'd127);
    queue_event(vao_pkg::OP_NOTE_OFF, 7'd66, 7'd127);
    queue_event(vao_pkg::OP_NOTE_ON, 7'd66, 7'd33);
    wait_idle();

    write_legato(1'b1);
    send_idle_pct  = 25;
    recv_stall_pct = 71;
    queue_random(430);
    wait_idle();

    write_legato(1'b0);
    send_idle_pct  = 71;
    recv_stall_pct = 25;
    queue_random(430);
    wait_idle();

    write_legato(1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(430);
    // Long receiver hold-off while the sender keeps offering items.
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    wait_idle();

    if (expected_cmds.size() != 0)
      n_errors += expected_cmds.size();
    $display("covered %0d note events under legato off and on, %0d voice commands checked",
             n_accepted, n_results);
    $display("steals: %0d, note offs with no held voice: %0d, errors: %0d",
             n_steals, n_silent_offs, n_errors);
    if (n_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
